>>> rtl/traffic_ca_ring_step_top_macros.svh
// Assertion macros shared by the ring-road RTL.
// Expects clk_i and rst_ni in the scope where a macro is used.
`ifndef TRAFFIC_CA_RING_STEP_TOP_MACROS_SVH
`define TRAFFIC_CA_RING_STEP_TOP_MACROS_SVH

// same-cycle implication
`define TCARS_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define TCARS_ASSERT_NXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/tcars_pkg.sv
// Package for the ring-road traffic automaton: codes, cell control types,
// reset constants and the LFSR byte draw. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package tcars_pkg;

  localparam int unsigned CellsDef = 256;
  localparam int unsigned RlenW    = 9;

  localparam logic [2:0]  MaxSpeedRst  = 3'd5;
  localparam logic [7:0]  DawdleRst    = 8'd64;
  localparam logic [8:0]  RingLenRst   = 9'd256;
  localparam logic [15:0] SeedRst      = 16'hACE1;
  localparam logic [15:0] SeedFallback = 16'hACE1;

  typedef enum logic [1:0] {
    CFG_MAX_SPEED = 2'd0,
    CFG_DAWDLE    = 2'd1,
    CFG_RING_LEN  = 2'd2,
    CFG_SEED      = 2'd3
  } cfg_idx_e;

  typedef enum logic [1:0] {
    ACT_LOAD = 2'd0,
    ACT_STEP = 2'd1,
    ACT_READ = 2'd2,
    ACT_NOP  = 2'd3
  } action_e;

  typedef enum logic [2:0] {
    CMD_NONE  = 3'd0,
    CMD_LOAD  = 3'd1,
    CMD_ACCEL = 3'd2,
    CMD_GAP   = 3'd3,
    CMD_DRAW  = 3'd4,
    CMD_MINIT = 3'd5,
    CMD_MOVE  = 3'd6
  } cell_cmd_e;

  typedef struct packed {
    cell_cmd_e  cmd;
    logic [2:0] vmax;
    logic [2:0] gap_lim;   // look-ahead distance minus one
    logic [7:0] prob;
    logic [3:0] load_val;
  } cell_ctl_t;

  // car in transit during the move phase
  typedef struct packed {
    logic       valid;
    logic [3:0] val;
    logic [2:0] rem;
  } mover_t;

  // eight shifts of the x^16+x^14+x^13+x^11+1 Fibonacci LFSR (right shift)
  function automatic logic [15:0] lfsr_step8(input logic [15:0] s);
    logic [15:0] r;
    logic        b;
    r = s;
    for (int k = 0; k < 8; k++) begin
      b = r[0] ^ r[2] ^ r[3] ^ r[5];
      r = {b, r[15:1]};
    end
    return r;
  endfunction

endpackage

`default_nettype wire

>>> rtl/tcars_cell.sv
// One road cell of the ring: content, speed, look-ahead bit, draw token and
// in-transit car. Depends on tcars_pkg and the assertion macro header.
`timescale 1ns / 1ps
`default_nettype none
`include "traffic_ca_ring_step_top_macros.svh"

module tcars_cell import tcars_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cell_ctl_t   ctl_i,
  input  logic        in_ring_i,
  input  logic        sel_i,
  input  logic        occ_next_i,
  output logic        occ_o,
  input  logic        tok_i,
  input  logic [15:0] lfsr_i,
  output logic        tok_o,
  output logic [15:0] lfsr_o,
  input  mover_t      mv_i,
  output mover_t      mv_o,
  output logic [3:0]  val_o
);

  logic [3:0]  val_q, val_d;
  logic [2:0]  spd_q, spd_d;
  logic [2:0]  rem_q, rem_d;
  logic        look_q, look_d;
  logic        tok_q;
  logic [15:0] ls_q;

  logic        car;
  logic [2:0]  spd_acc;
  logic [15:0] ls_draw;
  logic        draw_hit;

  always_comb begin
    car      = val_q != '0;
    spd_acc  = (val_q > {1'b0, ctl_i.vmax}) ? ctl_i.vmax : val_q[2:0];
    ls_draw  = lfsr_step8(lfsr_i);
    draw_hit = tok_i && in_ring_i && car && (spd_q != '0);

    val_d  = val_q;
    spd_d  = spd_q;
    rem_d  = rem_q;
    look_d = look_q;

    unique case (ctl_i.cmd)
      CMD_NONE: begin
      end
      CMD_LOAD: begin
        if (sel_i) val_d = ctl_i.load_val;
      end
      CMD_ACCEL: begin
        look_d = car;
        if (in_ring_i) spd_d = spd_acc;
      end
      CMD_GAP: begin
        // look_q of the successor carries the cell gap_lim+1 ahead
        look_d = occ_next_i;
        if (in_ring_i && car && occ_next_i && (spd_q > ctl_i.gap_lim)) begin
          spd_d = ctl_i.gap_lim;
        end
      end
      CMD_DRAW: begin
        if (draw_hit && (ls_draw[7:0] < ctl_i.prob)) spd_d = spd_q - 3'd1;
      end
      CMD_MINIT: begin
        if (in_ring_i && car) begin
          val_d = {1'b0, spd_q} + 4'd1;
          rem_d = spd_q;
        end
      end
      CMD_MOVE: begin
        if (in_ring_i) begin
          if (mv_i.valid) begin
            val_d = mv_i.val;
            rem_d = mv_i.rem - 3'd1;
          end else if (!(car && (rem_q == '0))) begin
            val_d = '0;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      val_q <= '0;
      tok_q <= 1'b0;
    end else begin
      val_q <= val_d;
      tok_q <= tok_i;
    end
  end

  always_ff @(posedge clk_i) begin
    spd_q  <= spd_d;
    rem_q  <= rem_d;
    look_q <= look_d;
    ls_q   <= draw_hit ? ls_draw : lfsr_i;
  end

  assign occ_o     = look_q;
  assign tok_o     = tok_q;
  assign lfsr_o    = ls_q;
  assign val_o     = val_q;
  assign mv_o.valid = in_ring_i && car && (rem_q != '0);
  assign mv_o.val   = val_q;
  assign mv_o.rem   = rem_q;

  `TCARS_ASSERT_IMP(a_move_no_clash, (ctl_i.cmd == CMD_MOVE) && in_ring_i && mv_i.valid,
                    !(car && (rem_q == '0)), "arriving car hits a parked car")
  `TCARS_ASSERT_IMP(a_gap_speed_cap, (ctl_i.cmd == CMD_GAP) && in_ring_i,
                    spd_q <= ctl_i.vmax, "speed above limit after accelerate")
  `TCARS_ASSERT_IMP(a_mover_rem, (ctl_i.cmd == CMD_MOVE) && mv_o.valid,
                    mv_o.rem <= ctl_i.vmax, "car still has more hops than the limit")

endmodule

`default_nettype wire

>>> rtl/traffic_ca_ring_step_top.sv
// Top level of the ring-road traffic automaton: sequencer, config registers,
// LFSR and the chain of tcars_cell. Depends on tcars_pkg and the macro header.
//
//   channel   handshake                    payload
//   command   start & !busy                action_i, cell_index_i, cell_value_i
//   result    res_valid_o (one cycle)      read_value_o, done_res_o
//   config    cfg_we_i                     cfg_idx_i, cfg_wdata_i
//
// Load and read act in the cycle they are accepted; the result strobe follows in the next cycle.
// An advance keeps busy high through accelerate, look-ahead, the draw token launched
// and walking the whole chain, move set-up and move.
// The draw phase is set by the token passing one cell per cycle.
// Reset empties the road at once and loads the seed; no clearing pass.
// Results cannot be held off by the receiver.
`timescale 1ns / 1ps
`default_nettype none
`include "traffic_ca_ring_step_top_macros.svh"

module traffic_ca_ring_step_top import tcars_pkg::*; #(
  parameter int unsigned CELLS = CellsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  action_i,
  input  logic [7:0]  cell_index_i,
  input  logic [3:0]  cell_value_i,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [15:0] cfg_wdata_i,
  output logic        res_valid_o,
  output logic [3:0]  read_value_o,
  output logic        done_res_o
);

  localparam int unsigned LenW = $clog2(CELLS + 1);
  localparam int unsigned CmpW = (LenW > RlenW) ? LenW : RlenW;
  localparam logic [CmpW-1:0] CellsC = CmpW'(CELLS);
  localparam logic [2:0] PhaseLast = 3'd6;   // last count of the look-ahead and hop phases
  localparam int unsigned MvW = $bits(mover_t);

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_ACCEL  = 7'b0000010,
    S_GAP    = 7'b0000100,
    S_LAUNCH = 7'b0001000,
    S_DRAW   = 7'b0010000,
    S_MINIT  = 7'b0100000,
    S_MOVE   = 7'b1000000
  } state_e;

  state_e      state_q, state_d;
  logic [2:0]  cnt_q, cnt_d;
  logic [15:0] lfsr_q, lfsr_d;
  logic [2:0]  maxv_q;
  logic [7:0]  prob_q;
  logic [8:0]  rlen_q;
  logic        res_valid_q, res_valid_d;
  logic [3:0]  res_rd_q, res_rd_d;
  logic        res_done_q, res_done_d;

  logic            start_acc;
  logic            launch;
  logic            load_go;
  cell_cmd_e       cmd;
  cell_ctl_t       ctl;
  logic [CmpW-1:0] rl_x, len_eff, len_m1, idx_x;
  logic            idx_ok;
  logic [3:0]      rd_bits;
  logic [MvW-1:0]  wrap_bits;
  mover_t          wrap_mv;

  logic [CELLS-1:0]       in_ring, is_last, hit, look_all, tok_all;
  logic [CELLS-1:0][3:0]  val_all;
  logic [CELLS-1:0][15:0] ls_all;
  mover_t [CELLS-1:0]     mv_all;

  assign rl_x    = CmpW'(rlen_q);
  assign len_eff = ((rl_x == '0) || (rl_x > CellsC)) ? CellsC : rl_x;
  assign len_m1  = len_eff - CmpW'(1);
  assign idx_x   = CmpW'(cell_index_i);
  assign idx_ok  = idx_x < len_eff;

  assign start_acc = start && (state_q == S_IDLE);
  assign busy      = state_q != S_IDLE;
  assign load_go   = cmd == CMD_LOAD;

  assign ctl.cmd      = cmd;
  assign ctl.vmax     = maxv_q;
  assign ctl.gap_lim  = cnt_q;
  assign ctl.prob     = prob_q;
  assign ctl.load_val = cell_value_i;

  // one-hot read select and the wrap link from the last ring cell to cell 0
  always_comb begin
    rd_bits   = '0;
    wrap_bits = '0;
    for (int k = 0; k < CELLS; k++) begin
      rd_bits   = rd_bits | (val_all[k] & {4{hit[k]}});
      wrap_bits = wrap_bits | (mv_all[k] & {MvW{is_last[k]}});
    end
  end
  assign wrap_mv = mover_t'(wrap_bits);

  for (genvar i = 0; i < CELLS; i++) begin : g_cell
    localparam logic [CmpW-1:0] Pos = CmpW'(i);
    logic   occ_next;
    logic   tok_in;
    logic [15:0] ls_in;
    mover_t mv_in;

    assign in_ring[i] = Pos < len_eff;
    assign is_last[i] = Pos == len_m1;
    assign hit[i]     = idx_x == Pos;

    if (i == CELLS - 1) begin : g_end
      assign occ_next = look_all[0];
    end else begin : g_mid
      assign occ_next = is_last[i] ? look_all[0] : look_all[i+1];
    end

    if (i == 0) begin : g_head
      assign tok_in = launch;
      assign ls_in  = lfsr_q;
      assign mv_in  = wrap_mv;
    end else begin : g_body
      assign tok_in = tok_all[i-1];
      assign ls_in  = ls_all[i-1];
      assign mv_in  = mv_all[i-1];
    end

    tcars_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .ctl_i      (ctl),
      .in_ring_i  (in_ring[i]),
      .sel_i      (load_go && hit[i] && idx_ok),
      .occ_next_i (occ_next),
      .occ_o      (look_all[i]),
      .tok_i      (tok_in),
      .lfsr_i     (ls_in),
      .tok_o      (tok_all[i]),
      .lfsr_o     (ls_all[i]),
      .mv_i       (mv_in),
      .mv_o       (mv_all[i]),
      .val_o      (val_all[i])
    );
  end

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    lfsr_d      = lfsr_q;
    res_valid_d = 1'b0;
    res_rd_d    = res_rd_q;
    res_done_d  = res_done_q;
    cmd         = CMD_NONE;
    launch      = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          unique case (action_i)
            ACT_LOAD: begin
              cmd         = CMD_LOAD;
              res_valid_d = 1'b1;
              res_rd_d    = '0;
              res_done_d  = idx_ok;
            end
            ACT_STEP: begin
              state_d = S_ACCEL;
            end
            ACT_READ: begin
              res_valid_d = 1'b1;
              res_rd_d    = idx_ok ? rd_bits : '0;
              res_done_d  = idx_ok;
            end
            ACT_NOP: begin
              res_valid_d = 1'b1;
              res_rd_d    = '0;
              res_done_d  = 1'b0;
            end
            default: begin
            end
          endcase
        end
      end
      S_ACCEL: begin
        cmd     = CMD_ACCEL;
        cnt_d   = '0;
        state_d = S_GAP;
      end
      S_GAP: begin
        cmd   = CMD_GAP;
        cnt_d = cnt_q + 3'd1;
        if (cnt_q == PhaseLast) state_d = S_LAUNCH;
      end
      S_LAUNCH: begin
        cmd     = CMD_DRAW;
        launch  = 1'b1;
        state_d = S_DRAW;
      end
      S_DRAW: begin
        cmd = CMD_DRAW;
        if (tok_all[CELLS-1]) begin
          lfsr_d  = ls_all[CELLS-1];
          state_d = S_MINIT;
        end
      end
      S_MINIT: begin
        cmd     = CMD_MINIT;
        cnt_d   = '0;
        state_d = S_MOVE;
      end
      S_MOVE: begin
        cmd   = CMD_MOVE;
        cnt_d = cnt_q + 3'd1;
        if (cnt_q == PhaseLast) begin
          state_d     = S_IDLE;
          res_valid_d = 1'b1;
          res_rd_d    = '0;
          res_done_d  = 1'b1;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    // seed write reloads the LFSR; zero would lock it up
    if (cfg_we_i && (cfg_idx_i == CFG_SEED)) begin
      lfsr_d = (cfg_wdata_i == '0) ? SeedFallback : cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      lfsr_q      <= SeedRst;
      res_valid_q <= 1'b0;
      res_rd_q    <= '0;
      res_done_q  <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      lfsr_q      <= lfsr_d;
      res_valid_q <= res_valid_d;
      res_rd_q    <= res_rd_d;
      res_done_q  <= res_done_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      maxv_q <= MaxSpeedRst;
      prob_q <= DawdleRst;
      rlen_q <= RingLenRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_MAX_SPEED: maxv_q <= cfg_wdata_i[2:0];
        CFG_DAWDLE:    prob_q <= cfg_wdata_i[7:0];
        CFG_RING_LEN:  rlen_q <= cfg_wdata_i[8:0];
        CFG_SEED: begin
        end
        default: begin
        end
      endcase
    end
  end

  assign res_valid_o  = res_valid_q;
  assign read_value_o = res_rd_q;
  assign done_res_o   = res_done_q;

  `TCARS_ASSERT_IMP(a_lfsr_live, 1'b1, lfsr_q != '0, "LFSR reached the all-zero lock")
  `TCARS_ASSERT_IMP(a_one_token, 1'b1, $onehot0(tok_all), "more than one draw token in the chain")
  `TCARS_ASSERT_IMP(a_fail_reads_zero, res_valid_q && !res_done_q, res_rd_q == '0,
                    "failed transfer carries a nonzero read value")
  `TCARS_ASSERT_NXT(a_quick_result, start_acc && (action_i != ACT_STEP), res_valid_q,
                    "load or read gave no result in the next cycle")

endmodule

`default_nettype wire
